// ===== rtl/dar_pkg.sv =====
// ----------------------------------------------------------------------------
// dar_pkg: shared types, codes and lookups for the direction auto-repeat block
// Register indexes, sequencer states and the direction to step-flag table.
// ----------------------------------------------------------------------------
package dar_pkg;

  localparam int unsigned TimeW   = 24;  // configured times, microseconds
  localparam int unsigned DtW     = 20;  // elapsed time per tick
  localparam int unsigned DirW    = 4;
  localparam int unsigned BtnW    = 6;
  localparam int unsigned CountW  = 8;   // repeat counter, ramp steps
  localparam int unsigned CdW     = 32;  // signed countdown
  localparam int unsigned DivNumW = 32;  // ramp product, divider dividend
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DirW-1:0] DirNone = 4'd0;
  localparam logic [DirW-1:0] DirMax  = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL_DELAY      = 3'd0,
    CFG_FAST_INITIAL_DELAY = 3'd1,
    CFG_SLOW_INTERVAL      = 3'd2,
    CFG_FAST_INTERVAL      = 3'd3,
    CFG_FAST_MODE_INTERVAL = 3'd4,
    CFG_RAMP_STEPS         = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  // Step flags, bit order: up, down, left, right
  typedef struct packed {
    logic right;
    logic left;
    logic down;
    logic up;
  } step_t;

  function automatic step_t dir_flags(input logic [DirW-1:0] dir);
    step_t f;
    f = '0;
    case (dir)
      4'd1:    f.right = 1'b1;
      4'd2:    begin f.up = 1'b1;   f.right = 1'b1; end
      4'd3:    f.up = 1'b1;
      4'd4:    begin f.up = 1'b1;   f.left = 1'b1; end
      4'd5:    f.left = 1'b1;
      4'd6:    begin f.down = 1'b1; f.left = 1'b1; end
      4'd7:    f.down = 1'b1;
      4'd8:    begin f.down = 1'b1; f.right = 1'b1; end
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/direction_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// direction_auto_repeat: typematic auto-repeat for an 8-way direction
// Steps on a new direction, repeats after a delay, ramps the repeat interval
// linearly from slow to fast using a serial divider.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      one frame tick
// m_axis    out  m_axis_tvalid/tready      one step result per tick
// cfg       in   cfg_valid_i/cfg_ready_o   register index + 24-bit data
//
// A tick runs ST_EVAL then ST_OUT when no ramp interval is needed, adds ST_FIN
// when a fixed interval reloads the countdown, and adds ST_MUL and ST_DIV before
// ST_FIN when the ramp interval is computed by the restoring divider.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register while the next tick is taken; m_axis stalls
// hold only that register, and a new result waits in ST_OUT until it drains.
// Reset (async, active low) loads the default register values and clears the
// held direction, repeat count and countdown.
//
module direction_auto_repeat
  import dar_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dar_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [dar_pkg::TimeW-1:0]     cfg_data_i,
  // input ticks
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] direction, [7:4] alt_direction, [13:8] buttons, [33:14] dt_us
  input  logic [39:0]                   s_axis_tdata,
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] step_up, [1] step_down, [2] step_left, [3] step_right,
  // [4] fast_mode, [10:5] pressed_mask
  output logic [15:0]                   m_axis_tdata
);

  // configuration registers
  logic [TimeW-1:0]  init_delay_q, fast_init_delay_q;
  logic [TimeW-1:0]  slow_iv_q, fast_iv_q, fast_mode_iv_q;
  logic [CountW-1:0] ramp_steps_q;

  // block state
  logic [DirW-1:0]   held_q, held_d;
  logic [CountW-1:0] rpt_q, rpt_d;
  logic [CdW-1:0]    cd_q, cd_d;

  // per-tick working registers
  state_e            state_q, state_d;
  logic [DirW-1:0]   dir_q;
  logic              fast_q;
  logic [BtnW-1:0]   btn_q;
  logic [DtW-1:0]    dt_q;
  logic [CdW:0]      c_q, c_d;        // countdown minus dt, signed
  logic [TimeW-1:0]  iv_q, iv_d;      // reload interval
  step_t             flags_q, flags_d;
  logic              neg_q, neg_d;    // ramp runs downward (fast < slow)

  // output register
  logic              out_valid_q;
  logic [15:0]       out_data_q;

  // input decode
  logic [DirW-1:0]   in_dir, in_alt, eff_dir;
  logic              eff_fast;
  logic              accept;

  // ramp arithmetic
  logic [TimeW-1:0]   span_mag;
  logic [DivNumW-1:0] prod;
  logic               div_start;
  logic               div_done;
  logic [DivNumW-1:0] div_quo;
  logic [CdW:0]       c_sub;
  logic [CdW+1:0]     c_sum;
  logic [CountW-1:0]  rpt_inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_delay_q      <= TimeW'(400000);
      fast_init_delay_q <= TimeW'(150000);
      slow_iv_q         <= TimeW'(150000);
      fast_iv_q         <= TimeW'(50000);
      fast_mode_iv_q    <= TimeW'(30000);
      ramp_steps_q      <= CountW'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_INITIAL_DELAY:      init_delay_q      <= cfg_data_i;
        CFG_FAST_INITIAL_DELAY: fast_init_delay_q <= cfg_data_i;
        CFG_SLOW_INTERVAL:      slow_iv_q         <= cfg_data_i;
        CFG_FAST_INTERVAL:      fast_iv_q         <= cfg_data_i;
        CFG_FAST_MODE_INTERVAL: fast_mode_iv_q    <= cfg_data_i;
        CFG_RAMP_STEPS:         ramp_steps_q      <= cfg_data_i[CountW-1:0];
        default:                ;
      endcase
    end
  end

  // Out-of-range codes count as none; the secondary direction drives only
  // when the main one is none.
  assign in_dir   = (s_axis_tdata[3:0] > DirMax) ? DirNone : s_axis_tdata[3:0];
  assign in_alt   = (s_axis_tdata[7:4] > DirMax) ? DirNone : s_axis_tdata[7:4];
  assign eff_fast = (in_dir == DirNone) && (in_alt != DirNone);
  assign eff_dir  = eff_fast ? in_alt : in_dir;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dir_q  <= eff_dir;
      fast_q <= eff_fast;
      btn_q  <= s_axis_tdata[13:8];
      dt_q   <= s_axis_tdata[33:14];
    end
  end

  // Shared arithmetic: countdown minus dt, saturating repeat increment,
  // |fast - slow| * n feeding the divider, and the final reload add.
  assign c_sub    = {cd_q[CdW-1], cd_q} - {{(CdW+1-DtW){1'b0}}, dt_q};
  assign rpt_inc  = (rpt_q == {CountW{1'b1}}) ? rpt_q : rpt_q + 1'b1;
  assign span_mag = neg_q ? (slow_iv_q - fast_iv_q) : (fast_iv_q - slow_iv_q);
  assign prod     = DivNumW'(span_mag) * DivNumW'(rpt_q);
  assign div_start = (state_q == ST_MUL);
  assign c_sum    = {c_q[CdW], c_q} + {{(CdW+2-TimeW){1'b0}}, iv_q};

  dar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (ramp_steps_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EVAL;
      ST_EVAL: begin
        if (dir_q == DirNone || dir_q != held_q || !c_sub[CdW] && c_sub != '0) begin
          state_d = ST_OUT;
        end else if (fast_q || rpt_inc >= ramp_steps_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    held_d  = held_q;
    rpt_d   = rpt_q;
    cd_d    = cd_q;
    c_d     = c_q;
    iv_d    = iv_q;
    flags_d = flags_q;
    neg_d   = neg_q;
    unique case (state_q)
      ST_EVAL: begin
        flags_d = '0;
        neg_d   = fast_iv_q < slow_iv_q;
        if (dir_q == DirNone) begin
          held_d = DirNone;
          rpt_d  = '0;
          cd_d   = '0;
        end else if (dir_q != held_q) begin
          // new direction: step at once, load the first-repeat delay
          held_d  = dir_q;
          rpt_d   = '0;
          cd_d    = CdW'(fast_q ? fast_init_delay_q : init_delay_q);
          flags_d = dir_flags(dir_q);
        end else if (!c_sub[CdW] && c_sub != '0) begin
          cd_d = c_sub[CdW-1:0];
        end else begin
          // countdown expired: repeat step and pick the reload interval
          rpt_d   = rpt_inc;
          c_d     = c_sub;
          flags_d = dir_flags(dir_q);
          iv_d    = fast_q ? fast_mode_iv_q : fast_iv_q;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          iv_d = neg_q ? (slow_iv_q - div_quo[TimeW-1:0])
                       : (slow_iv_q + div_quo[TimeW-1:0]);
        end
      end
      ST_FIN: begin
        // overdue past the whole interval: reload the bare interval, drop missed steps
        cd_d = c_sum[CdW+1] ? CdW'(iv_q) : c_sum[CdW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= DirNone;
      rpt_q   <= '0;
      cd_q    <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      rpt_q   <= rpt_d;
      cd_q    <= cd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    iv_q    <= iv_d;
    flags_q <= flags_d;
    neg_q   <= neg_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {5'b0, btn_q, fast_q, flags_q.right, flags_q.left,
                     flags_q.down, flags_q.up};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/dar_div.sv =====
// ----------------------------------------------------------------------------
// dar_div: radix-2 restoring divider, 32-bit dividend by 8-bit divisor
// One quotient bit per cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module dar_div
  import dar_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dar_pkg::DivNumW-1:0]   dividend_i,
  input  logic [dar_pkg::CountW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [dar_pkg::DivNumW-1:0]   quotient_o
);

  localparam int unsigned CntW = $clog2(DivNumW);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DivNumW-1:0]    quo_q, quo_d;
  logic [CountW-1:0]     rem_q, rem_d;
  logic [CountW-1:0]     dsr_q, dsr_d;
  logic [CountW:0]       shifted;
  logic [CountW:0]       trial;

  assign shifted = {rem_q, quo_q[DivNumW-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the trial fits one extra bit
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = trial[CountW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[CountW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sim/tb_direction_auto_repeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direction_auto_repeat: self-checking bench for the direction auto-repeat
// Sends frame ticks over s_axis and predicts each step result. Results from
// m_axis are checked field by field in order. Runs a directed opener, then
// random held-direction sequences under several timing settings and stalls.
// ----------------------------------------------------------------------------
module tb_direction_auto_repeat;
  import dar_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned MaxPrinted  = 40;

  // direction codes; 9..15 are invalid and read as none
  typedef enum logic [DirW-1:0] {
    DIR_NONE = 4'd0, DIR_R, DIR_UR, DIR_U, DIR_UL, DIR_L, DIR_DL, DIR_D, DIR_DR
  } dir_e;
  localparam logic [DirW-1:0] DirBadLo = 4'd9;
  localparam logic [DirW-1:0] DirBadHi = 4'd15;

  // one frame tick, highest field first
  typedef struct packed {
    logic [DtW-1:0]  dt;
    logic [BtnW-1:0] buttons;
    logic [DirW-1:0] alt;
    logic [DirW-1:0] dir;
  } tick_t;

  // one step result, highest field first
  typedef struct packed {
    logic [BtnW-1:0] pressed;
    logic            fast;
    logic            right;
    logic            left;
    logic            down;
    logic            up;
  } step_res_t;

  // one full register set
  typedef struct packed {
    logic [TimeW-1:0] init_delay;
    logic [TimeW-1:0] fast_init_delay;
    logic [TimeW-1:0] slow_iv;
    logic [TimeW-1:0] fast_iv;
    logic [TimeW-1:0] fast_mode_iv;
    logic [TimeW-1:0] ramp_raw;     // only the low byte is kept
  } cfg_set_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the timing registers and repeat state, a queue of
  // predicted step results, and the mismatch counter.
  // --------------------------------------------------------------------------
  class repeat_scoreboard;
    logic [TimeW-1:0]  init_delay;
    logic [TimeW-1:0]  fast_init_delay;
    logic [TimeW-1:0]  slow_iv;
    logic [TimeW-1:0]  fast_iv;
    logic [TimeW-1:0]  fast_mode_iv;
    logic [CountW-1:0] ramp_steps;
    logic [DirW-1:0]   held_dir;
    logic [CountW-1:0] repeat_cnt;
    int                countdown;
    step_res_t         expected_steps[$];
    int unsigned       errors;

    function new();
      init_delay      = 24'd400000;
      fast_init_delay = 24'd150000;
      slow_iv         = 24'd150000;
      fast_iv         = 24'd50000;
      fast_mode_iv    = 24'd30000;
      ramp_steps      = 8'd8;
      held_dir        = DIR_NONE;
      repeat_cnt      = '0;
      countdown       = 0;
      errors          = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [TimeW-1:0] value);
      case (idx)
        CFG_INITIAL_DELAY:      init_delay      = value;
        CFG_FAST_INITIAL_DELAY: fast_init_delay = value;
        CFG_SLOW_INTERVAL:      slow_iv         = value;
        CFG_FAST_INTERVAL:      fast_iv         = value;
        CFG_FAST_MODE_INTERVAL: fast_mode_iv    = value;
        CFG_RAMP_STEPS:         ramp_steps      = value[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_steps.size();
    endfunction

    function step_res_t dir_steps(logic [DirW-1:0] d);
      step_res_t r;
      r = '0;
      case (d)
        DIR_R:  r.right = 1'b1;
        DIR_UR: begin r.up = 1'b1;   r.right = 1'b1; end
        DIR_U:  r.up = 1'b1;
        DIR_UL: begin r.up = 1'b1;   r.left = 1'b1; end
        DIR_L:  r.left = 1'b1;
        DIR_DL: begin r.down = 1'b1; r.left = 1'b1; end
        DIR_D:  r.down = 1'b1;
        DIR_DR: begin r.down = 1'b1; r.right = 1'b1; end
        default: ;
      endcase
      return r;
    endfunction

    // interval after repeat number n; linear ramp truncated toward zero
    function longint reload_interval(logic [CountW-1:0] n, bit fast);
      longint span;
      if (fast) return longint'(fast_mode_iv);
      if (n >= ramp_steps) return longint'(fast_iv);
      span = (longint'(fast_iv) - longint'(slow_iv)) * longint'(n);
      return longint'(slow_iv) + span / longint'(ramp_steps);
    endfunction

    // called on every accepted tick, in acceptance order
    function void predict_steps(tick_t t);
      logic [DirW-1:0] d;
      logic [DirW-1:0] a;
      bit              fast;
      step_res_t       r;
      longint          c;
      longint          iv;
      d    = (t.dir > DirMax) ? DIR_NONE : t.dir;
      a    = (t.alt > DirMax) ? DIR_NONE : t.alt;
      fast = 1'b0;
      r    = '0;
      if (d == DIR_NONE && a != DIR_NONE) begin
        d    = a;
        fast = 1'b1;
      end
      if (d == DIR_NONE) begin
        held_dir   = DIR_NONE;
        repeat_cnt = '0;
        countdown  = 0;
      end else if (d != held_dir) begin
        // fresh direction: step now, arm first-repeat delay
        held_dir   = d;
        repeat_cnt = '0;
        countdown  = fast ? int'(fast_init_delay) : int'(init_delay);
        r          = dir_steps(d);
      end else begin
        c = longint'(countdown) - longint'(t.dt);
        if (c <= 0) begin
          if (repeat_cnt != 8'hFF) repeat_cnt++;
          iv = reload_interval(repeat_cnt, fast);
          c  = c + iv;
          if (c < 0) c = iv;   // far behind: drop missed steps
          r = dir_steps(d);
        end
        countdown = int'(c);
      end
      r.fast    = fast;
      r.pressed = t.buttons;
      expected_steps.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MaxPrinted)
        $display("%0t: step result mismatch: %s", $time, what);
    endtask

    task cmp_field(string name, logic [BtnW-1:0] got, logic [BtnW-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_steps(logic [15:0] data);
      step_res_t got;
      step_res_t want;
      got = data[$bits(step_res_t)-1:0];
      if (expected_steps.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_steps.pop_front();
      cmp_field("step_up",      BtnW'(got.up),    BtnW'(want.up));
      cmp_field("step_down",    BtnW'(got.down),  BtnW'(want.down));
      cmp_field("step_left",    BtnW'(got.left),  BtnW'(want.left));
      cmp_field("step_right",   BtnW'(got.right), BtnW'(want.right));
      cmp_field("fast_mode",    BtnW'(got.fast),  BtnW'(want.fast));
      cmp_field("pressed_mask", got.pressed, want.pressed);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_addr_i    = '0;
  logic [TimeW-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;

  repeat_scoreboard    sb = new();
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         cycle_count    = 0;

  direction_auto_repeat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock, starts low so time zero carries no edge
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hang guard. An honest run sends at most 948 ticks, and even with both sides
  // idling the cycle limit covers them many times over.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: values sampled at the edge are pre-edge values, since all
  // DUT and bench updates are nonblocking. Stalls are drawn every cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_steps(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // One tick transaction. tvalid stays high into the next call when there is
  // no gap, so it is never dropped and raised within one time step.
  task automatic drive_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_steps(t);
  endtask

  task automatic tick(input logic [DirW-1:0] dir, input logic [DirW-1:0] alt,
                      input logic [BtnW-1:0] buttons, input logic [DtW-1:0] dt);
    tick_t t;
    t.dir     = dir;
    t.alt     = alt;
    t.buttons = buttons;
    t.dt      = dt;
    drive_tick(t);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [TimeW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  // Registers change only with the pipe empty: every tick yields a result,
  // so an empty queue means the block is back to idle.
  task automatic load_settings(input cfg_set_t s);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    write_reg(CFG_INITIAL_DELAY,      s.init_delay);
    write_reg(CFG_FAST_INITIAL_DELAY, s.fast_init_delay);
    write_reg(CFG_SLOW_INTERVAL,      s.slow_iv);
    write_reg(CFG_FAST_INTERVAL,      s.fast_iv);
    write_reg(CFG_FAST_MODE_INTERVAL, s.fast_mode_iv);
    write_reg(CFG_RAMP_STEPS,         s.ramp_raw);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DtW-1:0] pick_dt();
    case ($urandom_range(4))
      0:       return '0;
      1:       return DtW'($urandom_range(2000));
      2:       return DtW'($urandom_range(200000));
      3:       return '1;
      default: return DtW'($urandom);
    endcase
  endfunction

  // "none" for the main field: real none or one of the invalid codes
  function automatic logic [DirW-1:0] none_code();
    if ($urandom_range(3) == 0) return DirW'($urandom_range(DirBadHi, DirBadLo));
    return DIR_NONE;
  endfunction

  // Random part of a phase. Mostly held-direction runs with a steady frame
  // time, in normal or fast mode, some broken mid-run; the rest pure noise.
  // long_hold > 0 makes the first run that long with no breaks.
  task automatic random_ticks(input int unsigned count, input int unsigned long_hold);
    int unsigned    sent;
    int unsigned    len;
    logic [DirW-1:0] code;
    bit             fast;
    bit             steady;
    logic [DtW-1:0] base_dt;
    tick_t          t;
    sent = 0;
    while (sent < count) begin
      if (long_hold == 0 && $urandom_range(99) < 25) begin
        t.dir     = DirW'($urandom_range(15));
        t.alt     = DirW'($urandom_range(15));
        t.buttons = BtnW'($urandom);
        t.dt      = DtW'($urandom);
        drive_tick(t);
        sent++;
      end else begin
        code    = DirW'($urandom_range(DIR_DR, DIR_R));
        fast    = 1'($urandom_range(1));
        steady  = (long_hold != 0);
        len     = steady ? long_hold : $urandom_range(40, 1);
        base_dt = steady ? 20'd1000 : pick_dt();
        long_hold = 0;
        for (int i = 0; i < len; i++) begin
          t.dir     = fast ? none_code() : code;
          t.alt     = fast ? code : DirW'($urandom_range(15));
          t.buttons = BtnW'($urandom);
          t.dt      = ($urandom_range(9) == 0) ? pick_dt() : base_dt;
          if (!steady && $urandom_range(39) == 0) begin
            // break the run: flip mode on the same code, or scramble it
            if ($urandom_range(1)) begin
              fast  = !fast;
              t.dir = fast ? none_code() : code;
              t.alt = code;
            end else begin
              t.dir = DirW'($urandom_range(15));
            end
          end
          drive_tick(t);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input cfg_set_t s, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned count,
                           input int unsigned long_hold);
    load_settings(s);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    random_ticks(count, long_hold);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_set_t s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opener at reset timing: 400 ms first delay, ramp 150->50 ms
    // over 8 repeats, 150 ms / 30 ms for fast mode.
    tick(DIR_NONE, DIR_NONE, 6'h3F, 20'hFFFFF);    // nothing held, all buttons
    tick(DIR_R,    DIR_NONE, 6'h01, 20'd0);        // new direction steps at once
    tick(DIR_R,    DirBadHi, 6'h02, 20'd400000);   // countdown lands exactly on 0
    tick(DIR_R,    DIR_UL,   6'h04, 20'd100000);   // counting, no step
    tick(DIR_R,    DIR_NONE, 6'h08, 20'hFFFFF);    // far overdue: no catch-up
    tick(DIR_NONE, DIR_R,    6'h10, 20'd0);        // same code, now fast: held
    tick(DirBadLo, DIR_R,    6'h20, 20'd200000);   // fast repeat, overdue
    tick(DirBadHi, DIR_UL,   6'h00, 20'd1);        // invalid main, fast new code
    tick(DirBadLo, 4'd12,    6'h15, 20'd7);        // both invalid: drop to none
    tick(DIR_U,    DIR_NONE, 6'h2A, 20'd0);
    tick(DIR_UL,   DIR_D,    6'h01, 20'd0);
    tick(DIR_L,    DIR_NONE, 6'h02, 20'd0);
    tick(DIR_DL,   DIR_NONE, 6'h04, 20'd0);
    tick(DIR_D,    DIR_NONE, 6'h08, 20'd0);
    tick(DIR_DR,   DIR_NONE, 6'h10, 20'd0);
    tick(DIR_UR,   DIR_NONE, 6'h20, 20'd150000);
    tick(DIR_UR,   DIR_NONE, 6'h00, 20'd150000);   // still counting
    tick(DIR_UR,   DIR_NONE, 6'h00, 20'd250000);   // first repeat, exact
    tick(DIR_UR,   DIR_NONE, 6'h00, 20'd137500);   // second repeat, exact
    tick(DIR_NONE, DIR_D,    6'h00, 20'd0);        // fast, new code
    tick(DIR_NONE, DIR_D,    6'h3F, 20'd150000);   // fast repeat
    tick(DIR_D,    DIR_NONE, 6'h00, 20'd30001);    // back to main, same code
    tick(DIR_NONE, DIR_NONE, 6'h00, 20'hFFFFF);

    // short times, mid ramp, no idling
    s = '{24'd3000, 24'd2000, 24'd1500, 24'd500, 24'd300, 24'd8};
    run_phase(s, 0, 0, 90, 0);
    // every time at maximum, longest ramp; sender gaps
    s = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd255};
    run_phase(s, 58, 0, 90, 0);
    // all zero with ramp of zero: every held tick repeats, long hold
    // saturates the repeat counter; receiver stalls
    s = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
    run_phase(s, 0, 58, 125, 280);
    // ramp upward, single-step ramp written with junk above the byte
    s = '{24'd1000, 24'd0, 24'd200, 24'd90000, 24'd1, 24'hFFFF01};
    run_phase(s, 35, 35, 90, 0);
    // widest downward ramp: max slow, zero fast
    s = '{24'd0, 24'd5000, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd255};
    run_phase(s, 0, 58, 90, 0);
    // back to reset timing
    s = '{24'd400000, 24'd150000, 24'd150000, 24'd50000, 24'd30000, 24'd8};
    run_phase(s, 35, 35, 90, 0);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
